// ===== rtl/ray_sphere_intersect_top_macros.svh =====
// Assertion macros for the ray-sphere intersection block.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef RAY_SPHERE_INTERSECT_TOP_MACROS_SVH
`define RAY_SPHERE_INTERSECT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge out of reset.
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_sphere_intersect: assertion failed");
// Next-cycle implication.
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_sphere_intersect: assertion failed");
`else
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rsi_pkg.sv =====
// Shared types, constants and helpers of the ray-sphere intersection block.
// No dependencies; used by rsi_sqrt_pipe and ray_sphere_intersect_top.
`timescale 1ns / 1ps
package rsi_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int QBITS      = 33;
    localparam int SQRT_STEPS = 64;
    localparam int NORM_W     = FRAC_BITS + 2;

    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_BITS;

    typedef logic signed [31:0] fx_t;
    typedef fx_t [2:0] vec_t;

    typedef struct packed {
        vec_t o;
        vec_t d;
        fx_t  tlo;
        fx_t  thi;
    } ray_t;

    // data that rides along the square-root pipe
    typedef struct packed {
        ray_t               ray;
        logic signed [64:0] h;
        logic [63:0]        a;
        logic               miss;
    } side_t;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

    function automatic fx_t sat_fx(input logic signed [64:0] v);
        logic signed [64:0] hi_lim;
        logic signed [64:0] lo_lim;
        hi_lim = 65'sd2147483647;
        lo_lim = -65'sd2147483648;
        if (v > hi_lim) return 32'sh7FFF_FFFF;
        if (v < lo_lim) return 32'sh8000_0000;
        return fx_t'(v[31:0]);
    endfunction
endpackage

// ===== rtl/ray_sphere_intersect_top.sv =====
// Ray-sphere intersection, fixed point Q16.16, fully pipelined.
// Each accepted ray yields its result item on the output register.
// Throughput: one ray per cycle; the 64-stage square root and the 33-stage root
// divider set the depth, every stage advances together unless the output is stalled.
// Reset: asynchronous active-low; clears all valid bits, center to 0, radius to 1.0.
`timescale 1ns / 1ps
`include "ray_sphere_intersect_top_macros.svh"
module ray_sphere_intersect_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    // ray input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                origin_x,
    input  logic signed [31:0]                origin_y,
    input  logic signed [31:0]                origin_z,
    input  logic signed [31:0]                dir_x,
    input  logic signed [31:0]                dir_y,
    input  logic signed [31:0]                dir_z,
    input  logic signed [31:0]                t_lower,
    input  logic signed [31:0]                t_upper,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [31:0]                hit_distance,
    output logic signed [31:0]                point_x,
    output logic signed [31:0]                point_y,
    output logic signed [31:0]                point_z,
    output logic signed [rsi_pkg::NORM_W-1:0] normal_x,
    output logic signed [rsi_pkg::NORM_W-1:0] normal_y,
    output logic signed [rsi_pkg::NORM_W-1:0] normal_z,
    output logic                              front_face
);
    // ------------------------------------------------------------------
    // Local types
    // ------------------------------------------------------------------
    typedef logic signed [63:0] prod_t;
    typedef logic signed [rsi_pkg::NORM_W-1:0] nrm_t;
    typedef logic signed [rsi_pkg::NORM_W+31:0] dn_t;

    // one step of the root divider: remainder and quotient so far
    typedef struct packed {
        logic [63:0]              rem;
        logic [rsi_pkg::QBITS-1:0] q;
    } dv_t;

    // data that rides along the root divider
    typedef struct packed {
        rsi_pkg::ray_t     ray;
        logic              miss;
        logic [1:0]        neg;
        logic [1:0]        ovf;
        logic [63:0]       a;
        logic [1:0][65:0]  mag;
    } rd_t;

    // one step of the normal divider
    typedef struct packed {
        logic [30:0]                    rem;
        logic [rsi_pkg::FRAC_BITS-1:0]  q;
    } nd_t;

    // data that rides along the normal divider
    typedef struct packed {
        rsi_pkg::ray_t  ray;
        rsi_pkg::fx_t   t;
        logic           hit;
        rsi_pkg::vec_t  p;
        logic [2:0]     neg;
        logic [2:0]     big;
    } ns_t;

    function automatic dv_t dv_step(input dv_t s, input logic [63:0] d, input logic b);
        logic [64:0] trial;
        dv_t r;
        trial = {s.rem, b};
        if (trial >= {1'b0, d})
        begin
            r.rem = 64'(trial - {1'b0, d});
            r.q   = {s.q[rsi_pkg::QBITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[63:0];
            r.q   = {s.q[rsi_pkg::QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // bit b of the scaled numerator mag * 2^FRAC_BITS
    function automatic logic num_bit(input logic [65:0] m, input int b);
        logic r;
        r = 1'b0;
        if (b >= rsi_pkg::FRAC_BITS) r = m[7'(b - rsi_pkg::FRAC_BITS)];
        return r;
    endfunction

    function automatic nd_t nd_step(input nd_t s, input logic [30:0] d);
        logic [31:0] trial;
        nd_t r;
        trial = {s.rem, 1'b0};
        if (trial >= {1'b0, d})
        begin
            r.rem = 31'(trial - {1'b0, d});
            r.q   = {s.q[rsi_pkg::FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[30:0];
            r.q   = {s.q[rsi_pkg::FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: the user must write them only while the pipe is empty
    // (the block does not enforce it), so every stage reads them directly.
    // ------------------------------------------------------------------
    rsi_pkg::fx_t  center_x_reg;
    rsi_pkg::fx_t  center_y_reg;
    rsi_pkg::fx_t  center_z_reg;
    logic [30:0]   radius_reg;
    rsi_pkg::vec_t ctr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= 31'(1) << rsi_pkg::FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (rsi_pkg::cfg_idx_t'(cfg_index))
                rsi_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                rsi_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                rsi_pkg::CFG_CENTER_Z: center_z_reg <= cfg_data;
                rsi_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[30:0];
            endcase
        end
    end

    assign ctr[0] = center_x_reg;
    assign ctr[1] = center_y_reg;
    assign ctr[2] = center_z_reg;

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the output register
    // holds an item the consumer is stalling.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    rsi_pkg::ray_t in_ray;
    always_comb
    begin
        in_ray.o[0] = origin_x;
        in_ray.o[1] = origin_y;
        in_ray.o[2] = origin_z;
        in_ray.d[0] = dir_x;
        in_ray.d[1] = dir_y;
        in_ray.d[2] = dir_z;
        in_ray.tlo  = t_lower;
        in_ray.thi  = t_upper;
    end

    // ------------------------------------------------------------------
    // Stage 1: oc = O - C, saturated per component
    // ------------------------------------------------------------------
    rsi_pkg::ray_t s1_ray_reg;
    rsi_pkg::vec_t s1_oc_reg;
    rsi_pkg::vec_t s1_oc_next;
    logic          s1_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_oc_next[i] = rsi_pkg::sat_fx(65'(in_ray.o[i]) - 65'(ctr[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ray_reg <= in_ray;
            s1_oc_reg  <= s1_oc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: component products and R*R
    // ------------------------------------------------------------------
    rsi_pkg::ray_t s2_ray_reg;
    prod_t         s2_dd_reg [0:2];
    prod_t         s2_oo_reg [0:2];
    prod_t         s2_od_reg [0:2];
    logic [61:0]   s2_r2_reg;
    logic          s2_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ray_reg <= s1_ray_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_dd_reg[i] <= s1_ray_reg.d[i] * s1_ray_reg.d[i];
                s2_oo_reg[i] <= s1_oc_reg[i] * s1_oc_reg[i];
                s2_od_reg[i] <= s1_oc_reg[i] * s1_ray_reg.d[i];
            end
            s2_r2_reg <= 62'(radius_reg) * 62'(radius_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: a = D.D, oc.oc, h = oc.D
    // ------------------------------------------------------------------
    rsi_pkg::ray_t      s3_ray_reg;
    logic [63:0]        s3_a_reg;
    logic [63:0]        s3_oc2_reg;
    logic signed [64:0] s3_h_reg;
    logic [61:0]        s3_r2_reg;
    logic               s3_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ray_reg <= s2_ray_reg;
            s3_a_reg   <= 64'(s2_dd_reg[0]) + 64'(s2_dd_reg[1]) + 64'(s2_dd_reg[2]);
            s3_oc2_reg <= 64'(s2_oo_reg[0]) + 64'(s2_oo_reg[1]) + 64'(s2_oo_reg[2]);
            s3_h_reg   <= 65'(s2_od_reg[0]) + 65'(s2_od_reg[1]) + 65'(s2_od_reg[2]);
            s3_r2_reg  <= s2_r2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |h| and |c| with the sign of c
    // ------------------------------------------------------------------
    rsi_pkg::ray_t      s4_ray_reg;
    logic [63:0]        s4_a_reg;
    logic signed [64:0] s4_h_reg;
    logic [63:0]        s4_hmag_reg;
    logic [63:0]        s4_cmag_reg;
    logic               s4_ge_reg;
    logic               s4_v_reg;
    logic               s4_ge_next;
    logic signed [64:0] s4_hneg;

    assign s4_ge_next = s3_oc2_reg >= 64'(s3_r2_reg);
    assign s4_hneg    = -s3_h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ray_reg  <= s3_ray_reg;
            s4_a_reg    <= s3_a_reg;
            s4_h_reg    <= s3_h_reg;
            s4_hmag_reg <= s3_h_reg[64] ? s4_hneg[63:0] : s3_h_reg[63:0];
            s4_cmag_reg <= s4_ge_next ? s3_oc2_reg - 64'(s3_r2_reg)
                                      : 64'(s3_r2_reg) - s3_oc2_reg;
            s4_ge_reg   <= s4_ge_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: 32x32 partial products of h*h and a*c
    // ------------------------------------------------------------------
    rsi_pkg::ray_t      s5_ray_reg;
    logic [63:0]        s5_a_reg;
    logic signed [64:0] s5_h_reg;
    logic               s5_ge_reg;
    logic [63:0]        s5_hll_reg, s5_hlh_reg, s5_hhh_reg;
    logic [63:0]        s5_all_reg, s5_alh_reg, s5_ahl_reg, s5_ahh_reg;
    logic               s5_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_ray_reg <= s4_ray_reg;
            s5_a_reg   <= s4_a_reg;
            s5_h_reg   <= s4_h_reg;
            s5_ge_reg  <= s4_ge_reg;
            s5_hll_reg <= 64'(s4_hmag_reg[31:0])  * 64'(s4_hmag_reg[31:0]);
            s5_hlh_reg <= 64'(s4_hmag_reg[31:0])  * 64'(s4_hmag_reg[63:32]);
            s5_hhh_reg <= 64'(s4_hmag_reg[63:32]) * 64'(s4_hmag_reg[63:32]);
            s5_all_reg <= 64'(s4_a_reg[31:0])  * 64'(s4_cmag_reg[31:0]);
            s5_alh_reg <= 64'(s4_a_reg[31:0])  * 64'(s4_cmag_reg[63:32]);
            s5_ahl_reg <= 64'(s4_a_reg[63:32]) * 64'(s4_cmag_reg[31:0]);
            s5_ahh_reg <= 64'(s4_a_reg[63:32]) * 64'(s4_cmag_reg[63:32]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: assemble h*h and a*c at 128 bits
    // ------------------------------------------------------------------
    rsi_pkg::ray_t      s6_ray_reg;
    logic [63:0]        s6_a_reg;
    logic signed [64:0] s6_h_reg;
    logic               s6_ge_reg;
    logic [127:0]       s6_sq_reg;
    logic [127:0]       s6_ac_reg;
    logic               s6_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_ray_reg <= s5_ray_reg;
            s6_a_reg   <= s5_a_reg;
            s6_h_reg   <= s5_h_reg;
            s6_ge_reg  <= s5_ge_reg;
            s6_sq_reg  <= {s5_hhh_reg, s5_hll_reg} + (128'(s5_hlh_reg) << 33);
            s6_ac_reg  <= {s5_ahh_reg, s5_all_reg} + (128'(s5_alh_reg) << 32)
                          + (128'(s5_ahl_reg) << 32);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: discriminant; drop to miss on negative disc or zero direction
    // ------------------------------------------------------------------
    logic [127:0]   s7_disc_reg;
    rsi_pkg::side_t s7_side_reg;
    logic           s7_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_side_reg.ray  <= s6_ray_reg;
            s7_side_reg.h    <= s6_h_reg;
            s7_side_reg.a    <= s6_a_reg;
            s7_side_reg.miss <= (s6_a_reg == '0) || (s6_ge_reg && (s6_sq_reg < s6_ac_reg));
            s7_disc_reg      <= s6_ge_reg ? s6_sq_reg - s6_ac_reg : s6_sq_reg + s6_ac_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root pipe
    // ------------------------------------------------------------------
    logic           sq_v;
    logic [63:0]    sq_root;
    rsi_pkg::side_t sq_side;

    rsi_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s7_v_reg),
        .disc      (s7_disc_reg),
        .side_in   (s7_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ------------------------------------------------------------------
    // Root setup: numerators -h -/+ s, sign, magnitude, overflow precheck
    // ------------------------------------------------------------------
    rd_t                r0_reg;
    logic               r0_v_reg;
    rd_t                r0_next;
    logic signed [66:0] r0_num [0:1];
    logic signed [66:0] r0_nh;
    logic signed [66:0] r0_sv;

    always_comb
    begin
        r0_nh = -(67'(sq_side.h));
        r0_sv = $signed({3'b000, sq_root});
        r0_num[0] = r0_nh - r0_sv;
        r0_num[1] = r0_nh + r0_sv;
        r0_next.ray  = sq_side.ray;
        r0_next.miss = sq_side.miss;
        r0_next.a    = sq_side.a;
        for (int j = 0; j < 2; j++)
        begin
            r0_next.neg[j] = r0_num[j][66];
            r0_next.mag[j] = r0_num[j][66] ? 66'(-r0_num[j]) : r0_num[j][65:0];
            // quotient would need more than QBITS bits: out of any interval
            r0_next.ovf[j] = (r0_next.mag[j] >> (rsi_pkg::QBITS - rsi_pkg::FRAC_BITS))
                             >= {2'b00, sq_side.a};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg <= r0_next;
        end
    end

    // ------------------------------------------------------------------
    // Root divider: both roots, one quotient bit per stage
    // ------------------------------------------------------------------
    dv_t [1:0]                 dv_reg [0:rsi_pkg::QBITS-1];
    rd_t                       rd_reg [0:rsi_pkg::QBITS-1];
    logic [rsi_pkg::QBITS-1:0] dv_v_reg;
    dv_t [1:0]                 dv_init;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            dv_init[j].rem = 64'(r0_reg.mag[j] >> (rsi_pkg::QBITS - rsi_pkg::FRAC_BITS));
            dv_init[j].q   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                dv_reg[0][j] <= dv_step(dv_init[j], r0_reg.a,
                                        num_bit(r0_reg.mag[j], rsi_pkg::QBITS - 1));
            end
            rd_reg[0] <= r0_reg;
            for (int k = 1; k < rsi_pkg::QBITS; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    dv_reg[k][j] <= dv_step(dv_reg[k-1][j], rd_reg[k-1].a,
                                            num_bit(rd_reg[k-1].mag[j],
                                                    rsi_pkg::QBITS - 1 - k));
                end
                rd_reg[k] <= rd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Root select: nearer root if inside [t_lower, t_upper], else farther
    // ------------------------------------------------------------------
    rsi_pkg::ray_t     t_ray_reg;
    rsi_pkg::fx_t      t_t_reg;
    logic              t_hit_reg;
    logic              t_v_reg;
    rd_t               t_side;
    logic signed [33:0] t_val [0:1];
    logic [1:0]        t_in;
    logic signed [33:0] t_lo34;
    logic signed [33:0] t_hi34;

    always_comb
    begin
        t_side = rd_reg[rsi_pkg::QBITS-1];
        t_lo34 = 34'(t_side.ray.tlo);
        t_hi34 = 34'(t_side.ray.thi);
        for (int j = 0; j < 2; j++)
        begin
            t_val[j] = t_side.neg[j] ? -$signed({1'b0, dv_reg[rsi_pkg::QBITS-1][j].q})
                                     :  $signed({1'b0, dv_reg[rsi_pkg::QBITS-1][j].q});
            t_in[j]  = !t_side.ovf[j] && (t_val[j] >= t_lo34) && (t_val[j] <= t_hi34);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_ray_reg <= t_side.ray;
            t_hit_reg <= !t_side.miss && (t_in[0] || t_in[1]);
            t_t_reg   <= t_in[0] ? t_val[0][31:0] : t_val[1][31:0];
        end
    end

    // ------------------------------------------------------------------
    // t * D
    // ------------------------------------------------------------------
    rsi_pkg::ray_t m_ray_reg;
    rsi_pkg::fx_t  m_t_reg;
    logic          m_hit_reg;
    prod_t         m_prod_reg [0:2];
    logic          m_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_ray_reg <= t_ray_reg;
            m_t_reg   <= t_t_reg;
            m_hit_reg <= t_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                m_prod_reg[i] <= t_t_reg * t_ray_reg.d[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // P = O + floor(t*D), saturated
    // ------------------------------------------------------------------
    rsi_pkg::ray_t p_ray_reg;
    rsi_pkg::fx_t  p_t_reg;
    logic          p_hit_reg;
    rsi_pkg::vec_t p_p_reg;
    logic          p_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ray_reg <= m_ray_reg;
            p_t_reg   <= m_t_reg;
            p_hit_reg <= m_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                p_p_reg[i] <= rsi_pkg::sat_fx(65'(m_ray_reg.o[i])
                                              + 65'(m_prod_reg[i] >>> rsi_pkg::FRAC_BITS));
            end
        end
    end

    // ------------------------------------------------------------------
    // Normal setup: P - C, sign, magnitude; |P - C| >= R clamps to 1.0
    // ------------------------------------------------------------------
    ns_t                n0_reg;
    nd_t [2:0]          n0_nd_reg;
    logic               n0_v_reg;
    logic signed [33:0] n0_pc [0:2];
    logic [32:0]        n0_mag [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n0_pc[i]  = 34'(p_p_reg[i]) - 34'(ctr[i]);
            n0_mag[i] = n0_pc[i][33] ? 33'(-n0_pc[i]) : n0_pc[i][32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg.ray <= p_ray_reg;
            n0_reg.t   <= p_t_reg;
            n0_reg.hit <= p_hit_reg;
            n0_reg.p   <= p_p_reg;
            for (int i = 0; i < 3; i++)
            begin
                n0_reg.neg[i]    <= n0_pc[i][33];
                n0_reg.big[i]    <= n0_mag[i] >= {2'b00, radius_reg};
                n0_nd_reg[i].rem <= n0_mag[i][30:0];
                n0_nd_reg[i].q   <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Normal divider: (P - C) * 2^FRAC_BITS / R, one bit per stage
    // ------------------------------------------------------------------
    nd_t [2:0]                     nd_reg [0:rsi_pkg::FRAC_BITS-1];
    ns_t                           ns_reg [0:rsi_pkg::FRAC_BITS-1];
    logic [rsi_pkg::FRAC_BITS-1:0] nd_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nd_reg[0][i] <= nd_step(n0_nd_reg[i], radius_reg);
            end
            ns_reg[0] <= n0_reg;
            for (int k = 1; k < rsi_pkg::FRAC_BITS; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nd_reg[k][i] <= nd_step(nd_reg[k-1][i], radius_reg);
                end
                ns_reg[k] <= ns_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Outward normal: clamp, sign, zero radius gives zero
    // ------------------------------------------------------------------
    ns_t        n1_reg;
    nrm_t       n1_n_reg [0:2];
    logic       n1_v_reg;
    nrm_t       n1_q [0:2];
    ns_t        n1_side;

    always_comb
    begin
        n1_side = ns_reg[rsi_pkg::FRAC_BITS-1];
        for (int i = 0; i < 3; i++)
        begin
            n1_q[i] = n1_side.big[i] ? rsi_pkg::NORM_ONE
                                     : $signed({2'b00, nd_reg[rsi_pkg::FRAC_BITS-1][i].q});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg <= n1_side;
            for (int i = 0; i < 3; i++)
            begin
                if (radius_reg == '0)
                    n1_n_reg[i] <= '0;
                else
                    n1_n_reg[i] <= n1_side.neg[i] ? -n1_q[i] : n1_q[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // D . n products
    // ------------------------------------------------------------------
    ns_t  d_reg;
    nrm_t d_n_reg  [0:2];
    dn_t  d_dn_reg [0:2];
    logic d_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= n1_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_n_reg[i]  <= n1_n_reg[i];
                d_dn_reg[i] <= n1_reg.ray.d[i] * n1_n_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: face the normal toward the ray; zero on miss
    // ------------------------------------------------------------------
    logic                 hit_reg;
    rsi_pkg::fx_t         hit_distance_reg;
    rsi_pkg::vec_t        point_reg;
    nrm_t                 normal_reg [0:2];
    logic                 front_face_reg;
    logic signed [rsi_pkg::NORM_W+33:0] f_dot;
    logic                 f_front;

    assign f_dot   = (rsi_pkg::NORM_W+34)'(d_dn_reg[0]) + (rsi_pkg::NORM_W+34)'(d_dn_reg[1])
                     + (rsi_pkg::NORM_W+34)'(d_dn_reg[2]);
    assign f_front = f_dot[rsi_pkg::NORM_W+33];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg          <= d_reg.hit;
            hit_distance_reg <= d_reg.hit ? d_reg.t : '0;
            front_face_reg   <= d_reg.hit && f_front;
            for (int i = 0; i < 3; i++)
            begin
                point_reg[i]  <= d_reg.hit ? d_reg.p[i] : '0;
                normal_reg[i] <= !d_reg.hit ? nrm_t'(0)
                                 : (f_front ? d_n_reg[i] : -d_n_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            s7_v_reg      <= 1'b0;
            r0_v_reg      <= 1'b0;
            dv_v_reg      <= '0;
            t_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            p_v_reg       <= 1'b0;
            n0_v_reg      <= 1'b0;
            nd_v_reg      <= '0;
            n1_v_reg      <= 1'b0;
            d_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            s7_v_reg      <= s6_v_reg;
            r0_v_reg      <= sq_v;
            dv_v_reg      <= {dv_v_reg[rsi_pkg::QBITS-2:0], r0_v_reg};
            t_v_reg       <= dv_v_reg[rsi_pkg::QBITS-1];
            m_v_reg       <= t_v_reg;
            p_v_reg       <= m_v_reg;
            n0_v_reg      <= p_v_reg;
            nd_v_reg      <= {nd_v_reg[rsi_pkg::FRAC_BITS-2:0], n0_v_reg};
            n1_v_reg      <= nd_v_reg[rsi_pkg::FRAC_BITS-1];
            d_v_reg       <= n1_v_reg;
            out_valid_reg <= d_v_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = hit_distance_reg;
    assign point_x      = point_reg[0];
    assign point_y      = point_reg[1];
    assign point_z      = point_reg[2];
    assign normal_x     = normal_reg[0];
    assign normal_y     = normal_reg[1];
    assign normal_z     = normal_reg[2];
    assign front_face   = front_face_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a stalled output freezes the pipe front
    `RSI_ASSERT_NEXT(a_stall_holds_front, clk, rst_n, out_valid_reg && out_stall, $stable(s1_ray_reg))
    // a miss reports zero distance and no front face
    `RSI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid_reg && !hit_reg, hit_distance_reg == 0 && front_face_reg == 1'b0)
    // the x component of the reported normal stays within [-1.0, +1.0]
    `RSI_ASSERT_NOW(a_normal_x_range, clk, rst_n, out_valid_reg, normal_reg[0] <= rsi_pkg::NORM_ONE && normal_reg[0] >= -rsi_pkg::NORM_ONE)
endmodule

// ===== rtl/rsi_sqrt_pipe.sv =====
// Pipelined integer floor square root of a 128-bit value, one root bit per stage.
// Carries rsi_pkg::side_t alongside; depends on rsi_pkg.
`timescale 1ns / 1ps
module rsi_sqrt_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2*rsi_pkg::SQRT_STEPS-1:0]    disc,
    input  rsi_pkg::side_t                      side_in,
    output logic                                out_valid,
    output logic [rsi_pkg::SQRT_STEPS-1:0]      root,
    output rsi_pkg::side_t                      side_out
);
    typedef struct packed {
        logic [rsi_pkg::SQRT_STEPS+1:0] rem;
        logic [rsi_pkg::SQRT_STEPS-1:0] root;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s, input logic [1:0] b);
        logic [rsi_pkg::SQRT_STEPS+3:0] trial;
        logic [rsi_pkg::SQRT_STEPS+3:0] cand;
        sq_t r;
        trial = {s.rem, b};
        cand  = {2'b00, s.root, 2'b01};
        if (trial >= cand) begin
            r.rem  = (rsi_pkg::SQRT_STEPS+2)'(trial - cand);
            r.root = {s.root[rsi_pkg::SQRT_STEPS-2:0], 1'b1};
        end
        else begin
            r.rem  = trial[rsi_pkg::SQRT_STEPS+1:0];
            r.root = {s.root[rsi_pkg::SQRT_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_t                                   st_reg   [0:rsi_pkg::SQRT_STEPS-1];
    logic [2*rsi_pkg::SQRT_STEPS-1:0]      disc_reg [0:rsi_pkg::SQRT_STEPS-1];
    rsi_pkg::side_t                        side_reg [0:rsi_pkg::SQRT_STEPS-1];
    logic [rsi_pkg::SQRT_STEPS-1:0]        v_reg;
    sq_t                                   st_zero;

    assign st_zero = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[rsi_pkg::SQRT_STEPS-2:0], in_valid};
        end
    end

    // stage k resolves root bit (SQRT_STEPS-1-k)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= sq_step(st_zero, disc[2*rsi_pkg::SQRT_STEPS-1 -: 2]);
            disc_reg[0] <= disc;
            side_reg[0] <= side_in;
            for (int k = 1; k < rsi_pkg::SQRT_STEPS; k++)
            begin
                st_reg[k]   <= sq_step(st_reg[k-1],
                                       disc_reg[k-1][2*(rsi_pkg::SQRT_STEPS-1-k) +: 2]);
                disc_reg[k] <= disc_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[rsi_pkg::SQRT_STEPS-1];
    assign root      = st_reg[rsi_pkg::SQRT_STEPS-1].root;
    assign side_out  = side_reg[rsi_pkg::SQRT_STEPS-1];
endmodule
